// ===== rtl/core/irpwd_pkg.sv =====
// ============================================================================
// irpwd_pkg
// shared types, register map and helpers for the ir pulse width decoder
// ============================================================================
package irpwd_pkg;

    // decoder phases
    localparam logic [1:0] PH_WAIT   = 2'd0;
    localparam logic [1:0] PH_LEADER = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;
    localparam logic [1:0] PH_SYNC   = 2'd3;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_LEADER_WINDOW   = 3'd0;
    localparam logic [2:0] REG_ZERO_WINDOW     = 3'd1;
    localparam logic [2:0] REG_ONE_WINDOW      = 3'd2;
    localparam logic [2:0] REG_REPEAT_WINDOW   = 3'd3;
    localparam logic [2:0] REG_FRAME_BITS      = 3'd4;
    localparam logic [2:0] REG_EXPECTED_CUSTOM = 3'd5;
    localparam logic [2:0] REG_REPEAT_ON       = 3'd6;
    localparam logic [2:0] REG_GAP_LIMIT       = 3'd7;

    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int WIDTH_W = 13;
    localparam int WIN_W   = 2 * WIDTH_W;

    // register reset values
    localparam logic [5:0] FRAME_BITS_RST = 6'd32;
    localparam logic [7:0] GAP_LIMIT_RST  = 8'd12;

    typedef struct packed {
        logic [WIN_W-1:0] leader_window;
        logic [WIN_W-1:0] zero_window;
        logic [WIN_W-1:0] one_window;
        logic [WIN_W-1:0] repeat_window;
        logic [5:0]       frame_bits;
        logic [15:0]      expected_custom;
        logic             repeat_on;
        logic [7:0]       gap_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  phase;
        logic [31:0] word;
        logic [5:0]  bits_left;
    } dec_state_t;

    typedef struct packed {
        logic       report;
        logic [7:0] key_byte;
        logic       is_repeat;
        logic       restart_release;
        logic [1:0] phase;
    } dec_result_t;

    // strict window test, width one bit wider so that low + 1 never wraps
    function automatic logic in_window(input logic [WIDTH_W:0] w,
                                       input logic [WIN_W-1:0] win);
        logic [WIDTH_W:0] lo;
        logic [WIDTH_W:0] hi;
        lo = {1'b0, win[WIDTH_W-1:0]};
        hi = {1'b0, win[WIN_W-1:WIDTH_W]};
        return (w > lo) && (w < hi);
    endfunction

endpackage

// ===== rtl/core/irpwd_regs.sv =====
// ============================================================================
// irpwd_regs
// apb register bank holding the decoder windows and frame settings
// ============================================================================
module irpwd_regs
    import irpwd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.leader_window   <= '0;
            cfg_reg.zero_window     <= '0;
            cfg_reg.one_window      <= '0;
            cfg_reg.repeat_window   <= '0;
            cfg_reg.frame_bits      <= FRAME_BITS_RST;
            cfg_reg.expected_custom <= '0;
            cfg_reg.repeat_on       <= 1'b1;
            cfg_reg.gap_limit       <= GAP_LIMIT_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_LEADER_WINDOW:   cfg_reg.leader_window   <= pwdata[WIN_W-1:0];
                REG_ZERO_WINDOW:     cfg_reg.zero_window     <= pwdata[WIN_W-1:0];
                REG_ONE_WINDOW:      cfg_reg.one_window      <= pwdata[WIN_W-1:0];
                REG_REPEAT_WINDOW:   cfg_reg.repeat_window   <= pwdata[WIN_W-1:0];
                REG_FRAME_BITS:      cfg_reg.frame_bits      <= pwdata[5:0];
                REG_EXPECTED_CUSTOM: cfg_reg.expected_custom <= pwdata[15:0];
                REG_REPEAT_ON:       cfg_reg.repeat_on       <= pwdata[0];
                REG_GAP_LIMIT:       cfg_reg.gap_limit       <= pwdata[7:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_LEADER_WINDOW:   prdata = {{(DATA_W-WIN_W){1'b0}}, cfg_reg.leader_window};
            REG_ZERO_WINDOW:     prdata = {{(DATA_W-WIN_W){1'b0}}, cfg_reg.zero_window};
            REG_ONE_WINDOW:      prdata = {{(DATA_W-WIN_W){1'b0}}, cfg_reg.one_window};
            REG_REPEAT_WINDOW:   prdata = {{(DATA_W-WIN_W){1'b0}}, cfg_reg.repeat_window};
            REG_FRAME_BITS:      prdata = {26'd0, cfg_reg.frame_bits};
            REG_EXPECTED_CUSTOM: prdata = {16'd0, cfg_reg.expected_custom};
            REG_REPEAT_ON:       prdata = {31'd0, cfg_reg.repeat_on};
            REG_GAP_LIMIT:       prdata = {24'd0, cfg_reg.gap_limit};
            default:             prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/irpwd_step.sv =====
// ============================================================================
// irpwd_step
// next-state and result logic for one measured pulse
// ============================================================================
module irpwd_step
    import irpwd_pkg::*;
(
    input  cfg_t               cfg,
    input  dec_state_t         cur,
    input  logic [WIDTH_W-1:0] width,
    input  logic [7:0]         gap_ticks,
    output dec_state_t         nxt,
    output dec_result_t        res
);

    logic [1:0]       phase_eff;
    logic [WIDTH_W:0] w_ext;
    logic [WIDTH_W:0] w_leader;
    logic [WIDTH_W:0] w_data;
    logic             hit_leader;
    logic             hit_zero;
    logic             hit_one;
    logic             hit_repeat;
    logic [5:0]       bit_idx;
    logic [5:0]       bits_dec;
    logic [31:0]      word_set;
    logic [31:0]      word_chk;
    logic             frame_ok;
    logic             report;
    logic             is_repeat;
    logic             restart;

    assign phase_eff = (gap_ticks > cfg.gap_limit) ? PH_WAIT : cur.phase;
    assign w_ext     = {1'b0, width};

    // a zero width stands for low + 1 of the leader window (leader test) or zero window (data tests)
    assign w_leader = (width == '0) ? ({1'b0, cfg.leader_window[WIDTH_W-1:0]} + 1'b1)
                                    : w_ext;
    assign w_data   = (width == '0) ? ({1'b0, cfg.zero_window[WIDTH_W-1:0]} + 1'b1)
                                    : w_ext;

    assign hit_leader = in_window(w_leader, cfg.leader_window);
    assign hit_zero   = in_window(w_data, cfg.zero_window);
    assign hit_one    = in_window(w_data, cfg.one_window);
    assign hit_repeat = in_window(w_ext, cfg.repeat_window);

    assign bit_idx  = cfg.frame_bits - cur.bits_left;
    assign bits_dec = cur.bits_left - 6'd1;

    always_comb
    begin
        word_set = cur.word;
        if (!bit_idx[5])
            word_set[bit_idx[4:0]] = 1'b1;
    end

    // frame check runs on the word as it stands after this pulse
    assign word_chk = ((phase_eff == PH_DATA) && !hit_zero && hit_one) ? word_set
                                                                      : cur.word;
    assign frame_ok = (word_chk[15:0] == cfg.expected_custom) &&
                      ((word_chk[23:16] ^ word_chk[31:24]) == 8'hFF);

    always_comb
    begin
        nxt       = cur;
        report    = 1'b0;
        is_repeat = 1'b0;
        restart   = 1'b0;
        case (phase_eff)
            PH_WAIT:
            begin
                nxt.phase     = PH_LEADER;
                nxt.word      = '0;
                nxt.bits_left = cfg.frame_bits;
            end
            PH_LEADER:
            begin
                nxt.phase     = hit_leader ? PH_DATA : PH_WAIT;
                nxt.word      = '0;
                nxt.bits_left = cfg.frame_bits;
            end
            PH_DATA:
            begin
                nxt.phase = PH_DATA;
                if (hit_zero)
                begin
                    nxt.bits_left = bits_dec;
                end
                else if (hit_one)
                begin
                    nxt.word      = word_set;
                    nxt.bits_left = bits_dec;
                end
                else
                begin
                    nxt.phase = PH_WAIT;
                end
                if (nxt.bits_left == '0)
                begin
                    nxt.phase = PH_SYNC;
                    report    = frame_ok;
                end
            end
            default:
            begin
                nxt.phase = PH_SYNC;
                if (hit_repeat)
                begin
                    if (cfg.repeat_on)
                    begin
                        report    = frame_ok;
                        is_repeat = frame_ok;
                        restart   = 1'b1;
                    end
                end
                else
                begin
                    restart = 1'b1;
                end
            end
        endcase
    end

    assign res.report          = report;
    assign res.key_byte        = report ? nxt.word[23:16] : 8'd0;
    assign res.is_repeat       = is_repeat;
    assign res.restart_release = restart;
    assign res.phase           = nxt.phase;

endmodule

// ===== rtl/core/ir_pulse_width_remote_decoder.sv =====
// ============================================================================
// ir_pulse_width_remote_decoder
// nec-style ir frame decoder working on measured pulse widths
// ============================================================================
// usage
//  - input stream s_*: one request per measured pulse, tdata = {gap_ticks, width}
//  - output stream m_*: exactly one result per pulse, in pulse order
//  - apb port: eight 32-bit registers at byte offsets 0x00..0x1c; the user
//    writes them only while no pulse is in flight, which the block does not
//    enforce; pready is tied high, reads return the value
//  - path: input register, then result register; one pulse per cycle while
//    m_tready is high; the decoder state (phase, word, bit count) is updated
//    by the same combinational step that loads the result register, so each
//    pulse sees the state left by the one before
//  - stall: while m_tready is low the result register holds, one more pulse
//    waits in the input register, and s_tready drops once both are full
//  - reset: both stages empty, decoder in the wait phase, word and count
//    cleared, registers at their defaults (frame of 32 bits, gap limit 12,
//    repeats enabled, all windows zero)
// ============================================================================
module ir_pulse_width_remote_decoder
    import irpwd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,  // [12:0] width, [20:13] gap_ticks, rest zero
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,  // [0] report, [8:1] key_byte, [9] is_repeat,
                                        // [10] restart_release, [12:11] phase
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t        cfg;

    // input stage
    logic               in_valid_reg;
    logic [WIDTH_W-1:0] in_width_reg;
    logic [7:0]         in_gap_reg;

    // decoder state
    dec_state_t  state_reg;
    dec_state_t  state_next;

    // result stage
    logic        out_valid_reg;
    dec_result_t out_reg;
    dec_result_t out_next;

    logic        out_load;
    logic        in_load;

    irpwd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    irpwd_step u_step (
        .cfg       (cfg),
        .cur       (state_reg),
        .width     (in_width_reg),
        .gap_ticks (in_gap_reg),
        .nxt       (state_next),
        .res       (out_next)
    );

    // the result register frees up when empty or when the sink takes it
    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: PH_WAIT, word: 32'd0, bits_left: 6'd0};
        end
        else
        begin
            if (in_load)
                in_valid_reg <= 1'b1;
            else if (out_load)
                in_valid_reg <= 1'b0;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            // state advances together with the result it belongs to
            if (out_load)
                state_reg <= state_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_width_reg <= s_tdata[WIDTH_W-1:0];
            in_gap_reg   <= s_tdata[WIDTH_W+7:WIDTH_W];
        end
        if (out_load)
            out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_reg.phase, out_reg.restart_release, out_reg.is_repeat,
                       out_reg.key_byte, out_reg.report};

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------

    // a key report, new or repeat, only comes out of a completed frame
    a_report_in_sync: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.report |-> out_reg.phase == PH_SYNC)
        else $error("key report outside the sync phase");

    // a repeat is always a report
    a_repeat_is_report: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.is_repeat |-> out_reg.report)
        else $error("repeat flagged without a report");

    // release restart only happens in sync
    a_restart_in_sync: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.restart_release |-> out_reg.phase == PH_SYNC)
        else $error("release restart outside the sync phase");

    // the waiting result always shows the phase the decoder is in
    a_phase_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.phase == state_reg.phase)
        else $error("result phase differs from decoder phase");

endmodule
